// ----- sv/fdw_pkg.sv -----
package fdw_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT_ENTRY,
        ST_DIV,
        ST_EMIT_FAT
    } state_t;

    // input operations
    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_ENTRY   = 3'd0;
    localparam logic [2:0] KIND_FAT_REQ = 3'd1;
    localparam logic [2:0] KIND_CONT    = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_REFUSED = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_DATA_START  = 3'd0;
    localparam logic [2:0] REG_FIRST_CLUS  = 3'd1;
    localparam logic [2:0] REG_SEC_PER_CL  = 3'd2;
    localparam logic [2:0] REG_ENT_PER_SEC = 3'd3;
    localparam logic [2:0] REG_FAT_START   = 3'd4;
    localparam logic [2:0] REG_FAT_WORDS   = 3'd5;

    localparam logic [31:0] END_OF_CHAIN = 32'h0FFF_FFFF;

endpackage

// ----- sv/fat32_directory_walker.sv -----
// sequence: an open gives no beat; refusals and fat replies give one registered beat
// after acceptance; a next item gives its entry beat after an 8-step serial multiply
// on sectors per cluster, then a fat request beat after a 32-step serial divide
// when the cluster ends
// flow: one item at a time, taken only when idle and the result register is free
// reset: aresetn synchronous active low, config and control registers to defaults, no directory open
module fat32_directory_walker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_start_cluster,
    input  logic [31:0] s_fat_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_sector_address,
    output logic [9:0]  m_word_index,
    output logic        m_sector_read_needed,
    output logic        m_last
);
    import fdw_pkg::*;

    // configuration
    logic [31:0] data_start_reg;
    logic [27:0] first_clus_reg;
    logic [7:0]  spc_reg;
    logic [7:0]  eps_reg;
    logic [31:0] fat_start_reg;
    logic [10:0] fwps_reg;

    // walk state
    logic [31:0] cluster_reg;
    logic [6:0]  entry_cnt_reg;
    logic [6:0]  sector_cnt_reg;
    logic        awaiting_reg;
    logic        done_reg;

    // sequencer and datapath
    state_t      state_reg, state_next;
    logic [2:0]  step_reg;
    logic [4:0]  bit_reg;
    logic [31:0] acc_reg;
    logic [31:0] mcand_reg;
    logic [7:0]  mplier_reg;
    logic [31:0] quo_reg;
    logic [10:0] rem_reg;
    logic [10:0] divisor_reg;
    logic [6:0]  ent_idx_reg;
    logic        ent_rd_reg;
    logic        fat_req_reg;

    // output register
    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [31:0] m_addr_reg;
    logic [9:0]  m_idx_reg;
    logic        m_rd_reg;
    logic        m_last_reg;

    logic        slot_free;
    logic        accept;
    logic        load_entry;
    logic        load_fat;

    // counter bumps for a next item
    logic [7:0]  ent_inc, sec_inc;
    logic        ent_wrap, sec_wrap, fat_req;
    logic [6:0]  entry_cnt_next, sector_cnt_next;
    logic        next_ok;

    // one restoring division step
    logic [11:0] trial;
    logic        trial_ge;

    assign ent_inc  = {1'b0, entry_cnt_reg} + 8'd1;
    assign sec_inc  = {1'b0, sector_cnt_reg} + 8'd1;
    assign ent_wrap = (ent_inc >= eps_reg) || ent_inc[7];
    assign sec_wrap = (sec_inc >= spc_reg) || sec_inc[7];
    assign fat_req  = ent_wrap && sec_wrap;
    assign entry_cnt_next  = ent_wrap ? 7'd0 : ent_inc[6:0];
    assign sector_cnt_next = ent_wrap ? (sec_wrap ? 7'd0 : sec_inc[6:0]) : sector_cnt_reg;
    assign next_ok = !awaiting_reg && !done_reg;

    assign trial    = {rem_reg, quo_reg[31]};
    assign trial_ge = trial >= {1'b0, divisor_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_operation == OP_NEXT && next_ok) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (step_reg == 3'd7) state_next = ST_EMIT_ENTRY;
            end
            ST_EMIT_ENTRY: begin
                if (slot_free) state_next = fat_req_reg ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (bit_reg == 5'd31) state_next = ST_EMIT_FAT;
            end
            ST_EMIT_FAT: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake and load strobes
    always_comb begin
        slot_free  = !m_valid_reg || m_ready;
        s_ready    = 1'b0;
        load_entry = 1'b0;
        load_fat   = 1'b0;
        unique case (state_reg)
            ST_IDLE:       s_ready    = slot_free;
            ST_MUL:        s_ready    = 1'b0;
            ST_EMIT_ENTRY: load_entry = slot_free;
            ST_DIV:        s_ready    = 1'b0;
            ST_EMIT_FAT:   load_fat   = slot_free;
            default:       s_ready    = 1'b0;
        endcase
    end

    assign accept = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_start_reg <= 32'd0;
            first_clus_reg <= 28'd2;
            spc_reg        <= 8'd8;
            eps_reg        <= 8'd16;
            fat_start_reg  <= 32'd0;
            fwps_reg       <= 11'd128;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DATA_START:  data_start_reg <= cfg_wdata;
                REG_FIRST_CLUS:  first_clus_reg <= cfg_wdata[27:0];
                REG_SEC_PER_CL:  spc_reg        <= cfg_wdata[7:0];
                REG_ENT_PER_SEC: eps_reg        <= cfg_wdata[7:0];
                REG_FAT_START:   fat_start_reg  <= cfg_wdata;
                REG_FAT_WORDS:   fwps_reg       <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cluster_reg    <= 32'd0;
            entry_cnt_reg  <= 7'd0;
            sector_cnt_reg <= 7'd0;
            awaiting_reg   <= 1'b0;
            done_reg       <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            // every accepted item except an open or a good next gives a beat at once
            if (load_entry || load_fat ||
                (accept && s_operation != OP_OPEN &&
                 !(s_operation == OP_NEXT && next_ok))) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (s_operation == OP_OPEN) begin
                    cluster_reg    <= s_start_cluster;
                    entry_cnt_reg  <= 7'd0;
                    sector_cnt_reg <= 7'd0;
                    awaiting_reg   <= 1'b0;
                    done_reg       <= 1'b0;
                end else begin
                    if (s_operation == OP_NEXT && next_ok) begin
                        entry_cnt_reg  <= entry_cnt_next;
                        sector_cnt_reg <= sector_cnt_next;
                        awaiting_reg   <= fat_req;
                    end
                    if (s_operation == OP_REPLY && awaiting_reg) begin
                        awaiting_reg <= 1'b0;
                        cluster_reg  <= s_fat_word;
                        done_reg     <= (s_fat_word == END_OF_CHAIN);
                    end
                end
            end
        end
    end

    // serial multiply and divide datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                // sector base and offset start the accumulator
                acc_reg     <= data_start_reg + {25'd0, sector_cnt_reg};
                mcand_reg   <= cluster_reg - {4'd0, first_clus_reg};
                mplier_reg  <= spc_reg;
                step_reg    <= 3'd0;
                ent_idx_reg <= entry_cnt_reg;
                ent_rd_reg  <= (entry_cnt_reg == 7'd0);
                fat_req_reg <= fat_req;
            end
            ST_MUL: begin
                if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[30:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[7:1]};
                step_reg   <= step_reg + 3'd1;
            end
            ST_EMIT_ENTRY: begin
                quo_reg     <= cluster_reg;
                rem_reg     <= 11'd0;
                bit_reg     <= 5'd0;
                divisor_reg <= (fwps_reg == 11'd0) ? 11'd1 : fwps_reg;
            end
            ST_DIV: begin
                rem_reg <= trial_ge ? 11'(trial - {1'b0, divisor_reg}) : trial[10:0];
                quo_reg <= {quo_reg[30:0], trial_ge};
                bit_reg <= bit_reg + 5'd1;
            end
            default: ;
        endcase
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (load_entry) begin
            m_kind_reg <= KIND_ENTRY;
            m_addr_reg <= acc_reg;
            m_idx_reg  <= {3'd0, ent_idx_reg};
            m_rd_reg   <= ent_rd_reg;
            m_last_reg <= !fat_req_reg;
        end else if (load_fat) begin
            m_kind_reg <= KIND_FAT_REQ;
            m_addr_reg <= fat_start_reg + quo_reg;
            m_idx_reg  <= rem_reg[9:0];
            m_rd_reg   <= 1'b0;
            m_last_reg <= 1'b1;
        end else if (accept && s_operation != OP_OPEN) begin
            m_addr_reg <= 32'd0;
            m_idx_reg  <= 10'd0;
            m_rd_reg   <= 1'b0;
            m_last_reg <= 1'b1;
            if (s_operation == OP_REPLY && awaiting_reg)
                m_kind_reg <= (s_fat_word == END_OF_CHAIN) ? KIND_END : KIND_CONT;
            else
                m_kind_reg <= KIND_REFUSED;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_kind               = m_kind_reg;
    assign m_sector_address     = m_addr_reg;
    assign m_word_index         = m_idx_reg;
    assign m_sector_read_needed = m_rd_reg;
    assign m_last               = m_last_reg;

    // checks
    a_div_awaits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> awaiting_reg)
        else $error("divide running with no fat request pending");

    a_mul_open: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> !done_reg)
        else $error("entry address computed on a finished chain");

    a_fat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == KIND_FAT_REQ |-> m_last_reg && awaiting_reg)
        else $error("fat request beat malformed");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_entry || load_fat) |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import fdw_pkg::*;

    // operation code with no defined meaning
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sector_address;
        logic [9:0]  word_index;
        logic        sector_read_needed;
        logic        last;
    } beat_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [31:0] s_start_cluster;
    logic [31:0] s_fat_word;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [31:0] m_sector_address;
    logic [9:0]  m_word_index;
    logic        m_sector_read_needed;
    logic        m_last;

    // walker copy of the configuration registers
    logic [31:0] cfg_data_start;
    logic [27:0] cfg_first_cluster;
    logic [7:0]  cfg_sec_per_clus;
    logic [7:0]  cfg_ent_per_sec;
    logic [31:0] cfg_fat_start;
    logic [10:0] cfg_fat_words;

    // walker copy of the directory position
    logic [31:0] cur_cluster;
    logic [6:0]  entry_pos;
    logic [6:0]  sector_pos;
    logic        fat_pending;
    logic        walk_ended;

    beat_t awaited_beats[$];
    int    mismatch_count = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;

    fat32_directory_walker uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_start_cluster      (s_start_cluster),
        .s_fat_word           (s_fat_word),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_kind               (m_kind),
        .m_sector_address     (m_sector_address),
        .m_word_index         (m_word_index),
        .m_sector_read_needed (m_sector_read_needed),
        .m_last               (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // overall time limit
    initial begin
        #60_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void count_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endfunction

    function automatic void push_beat(input logic [2:0] kind, input logic [31:0] addr,
                                      input logic [9:0] idx, input logic rd, input logic last);
        beat_t b;
        b.kind = kind;
        b.sector_address = addr;
        b.word_index = idx;
        b.sector_read_needed = rd;
        b.last = last;
        awaited_beats.push_back(b);
    endfunction

    // true when the incremented counter hits its limit or the 7-bit ceiling
    function automatic logic counter_wraps(input logic [6:0] ctr, input logic [7:0] limit);
        logic [7:0] nxt;
        nxt = {1'b0, ctr} + 8'd1;
        return (nxt >= limit) || (nxt >= 8'd128);
    endfunction

    // next position of the directory walk and the beats it produces
    function automatic void walker_step(input logic [1:0] op, input logic [31:0] start,
                                        input logic [31:0] word);
        logic [31:0] addr;
        logic [31:0] divisor;
        logic [6:0]  idx;
        logic        rd;
        logic        clus_end;
        case (op)
            OP_OPEN: begin
                cur_cluster = start;
                entry_pos = '0;
                sector_pos = '0;
                fat_pending = 1'b0;
                walk_ended = 1'b0;
            end
            OP_NEXT: begin
                if (fat_pending || walk_ended) begin
                    push_beat(KIND_REFUSED, '0, '0, 1'b0, 1'b1);
                end else begin
                    addr = cfg_data_start
                         + 32'(cfg_sec_per_clus) * (cur_cluster - 32'(cfg_first_cluster))
                         + 32'(sector_pos);
                    idx = entry_pos;
                    rd = (entry_pos == '0);
                    clus_end = 1'b0;
                    if (counter_wraps(entry_pos, cfg_ent_per_sec)) begin
                        entry_pos = '0;
                        if (counter_wraps(sector_pos, cfg_sec_per_clus)) begin
                            sector_pos = '0;
                            clus_end = 1'b1;
                        end else begin
                            sector_pos = sector_pos + 7'd1;
                        end
                    end else begin
                        entry_pos = entry_pos + 7'd1;
                    end
                    push_beat(KIND_ENTRY, addr, {3'b000, idx}, rd, !clus_end);
                    if (clus_end) begin
                        divisor = (cfg_fat_words == '0) ? 32'd1 : 32'(cfg_fat_words);
                        push_beat(KIND_FAT_REQ, cfg_fat_start + cur_cluster / divisor,
                                  10'(cur_cluster % divisor), 1'b0, 1'b1);
                        fat_pending = 1'b1;
                    end
                end
            end
            OP_REPLY: begin
                if (fat_pending) begin
                    fat_pending = 1'b0;
                    cur_cluster = word;
                    if (word == END_OF_CHAIN) begin
                        walk_ended = 1'b1;
                        push_beat(KIND_END, '0, '0, 1'b0, 1'b1);
                    end else begin
                        push_beat(KIND_CONT, '0, '0, 1'b0, 1'b1);
                    end
                end else begin
                    push_beat(KIND_REFUSED, '0, '0, 1'b0, 1'b1);
                end
            end
            default: begin
                push_beat(KIND_REFUSED, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // compare each result beat with the oldest awaited one
    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_beats.size() == 0) begin
                count_failure($sformatf("unexpected beat: kind %0d addr %h idx %0d rd %b last %b",
                              m_kind, m_sector_address, m_word_index,
                              m_sector_read_needed, m_last));
            end else begin
                want = awaited_beats.pop_front();
                if (m_kind !== want.kind || m_sector_address !== want.sector_address ||
                    m_word_index !== want.word_index ||
                    m_sector_read_needed !== want.sector_read_needed ||
                    m_last !== want.last) begin
                    count_failure($sformatf(
                        "beat mismatch: exp kind %0d addr %h idx %0d rd %b last %b, got kind %0d addr %h idx %0d rd %b last %b",
                        want.kind, want.sector_address, want.word_index,
                        want.sector_read_needed, want.last, m_kind, m_sector_address,
                        m_word_index, m_sector_read_needed, m_last));
                end
            end
        end
    end

    // one item on the input channel, called and left at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [31:0] start,
                             input logic [31:0] word);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_start_cluster <= start;
        s_fat_word <= word;
        do @(posedge aclk); while (!s_ready);
        walker_step(op, start, word);
        @(negedge aclk);
    endtask

    // input quiet, all beats in, then room for a late fat request
    task automatic wait_idle();
        int guard;
        s_valid <= 1'b0;
        guard = 0;
        while (awaited_beats.size() != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (60) @(negedge aclk);
    endtask

    task automatic put_register(input logic [2:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        case (idx)
            REG_DATA_START:  cfg_data_start = value;
            REG_FIRST_CLUS:  cfg_first_cluster = value[27:0];
            REG_SEC_PER_CL:  cfg_sec_per_clus = value[7:0];
            REG_ENT_PER_SEC: cfg_ent_per_sec = value[7:0];
            REG_FAT_START:   cfg_fat_start = value;
            REG_FAT_WORDS:   cfg_fat_words = value[10:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [31:0] data_start, input logic [31:0] first_clus,
                               input logic [31:0] spc, input logic [31:0] eps,
                               input logic [31:0] fat_start, input logic [31:0] fat_words);
        cfg_wr_en <= 1'b1;
        put_register(REG_DATA_START, data_start);
        put_register(REG_FIRST_CLUS, first_clus);
        put_register(REG_SEC_PER_CL, spc);
        put_register(REG_ENT_PER_SEC, eps);
        put_register(REG_FAT_START, fat_start);
        put_register(REG_FAT_WORDS, fat_words);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_cluster();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2, 3, 4: return $urandom_range(0, 32'h0FFF_FFFF);
            default: return 32'(cfg_first_cluster) + $urandom_range(0, 40);
        endcase
    endfunction

    // refusals before anything is opened, then a short walk on reset registers
    task automatic test_after_reset();
        send_idle_pct = 30;
        recv_stall_pct = 30;
        send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_REPLY, $urandom, $urandom);
        send_item(OP_UNUSED, $urandom, $urandom);
        send_item(OP_OPEN, 32'd5, $urandom);
        send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_NEXT, $urandom, $urandom);
        wait_idle();
    endtask

    // zero limits act as one, zero fat divisor, all-ones addresses, chain end
    task automatic test_chain_ends();
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_OPEN, 32'd0, $urandom);
        send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_REPLY, $urandom, END_OF_CHAIN);
        send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_REPLY, $urandom, $urandom);
        send_item(OP_OPEN, 32'hFFFF_FFFF, $urandom);
        send_item(OP_NEXT, $urandom, $urandom);
        // open while a fat reply is still owed
        send_item(OP_OPEN, 32'h0000_1234, $urandom);
        send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_REPLY, $urandom, 32'hFFFF_FFFF);
        send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_REPLY, $urandom, 32'h0FFF_FFFE);
        send_item(OP_UNUSED, $urandom, $urandom);
        wait_idle();
    endtask

    // limits above 128 cap the counters, large fat remainders
    task automatic test_counter_limits();
        send_idle_pct = 0;
        recv_stall_pct = 20;
        load_config($urandom, $urandom, 32'd1, 32'd200, $urandom, 32'd2047);
        send_item(OP_OPEN, 32'd2046, $urandom);
        repeat (128) send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_REPLY, $urandom, 32'h1000_0000 | $urandom);
        wait_idle();
        load_config($urandom, $urandom, 32'd255, 32'd1, $urandom, 32'd1024);
        send_item(OP_OPEN, $urandom, $urandom);
        repeat (128) send_item(OP_NEXT, $urandom, $urandom);
        send_item(OP_REPLY, $urandom, END_OF_CHAIN);
        wait_idle();
    endtask

    // mostly well-formed walks across random chains, some noise
    task automatic test_random_walks(input int items, input int send_pct, input int recv_pct,
                                     input logic range_lows);
        logic [1:0]  op;
        logic [31:0] fat_words;
        if (range_lows) begin
            load_config(32'd0, 32'd0, 32'd1, 32'd16, 32'd0, 32'd128);
        end else begin
            case ($urandom_range(4))
                0:       fat_words = 32'd0;
                1:       fat_words = 32'd1;
                2:       fat_words = 32'd2047;
                3:       fat_words = $urandom;
                default: fat_words = $urandom_range(128, 1024);
            endcase
            load_config($urandom, $urandom,
                        ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 4),
                        ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 6),
                        $urandom, fat_words);
        end
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 12) begin
                op = 2'($urandom_range(3));
                send_item(op, $urandom, $urandom);
            end else if (walk_ended || $urandom_range(99) < 2) begin
                send_item(OP_OPEN, pick_cluster(), $urandom);
            end else if (fat_pending) begin
                send_item(OP_REPLY, $urandom,
                          ($urandom_range(3) == 0) ? END_OF_CHAIN : pick_cluster());
            end else begin
                send_item(OP_NEXT, $urandom, $urandom);
            end
        end
        wait_idle();
    endtask

    initial begin
        cfg_wr_en = 1'b0;
        cfg_index = REG_DATA_START;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_operation = OP_OPEN;
        s_start_cluster = '0;
        s_fat_word = '0;
        aresetn = 1'b0;

        // register and position values after reset
        cfg_data_start = '0;
        cfg_first_cluster = 28'd2;
        cfg_sec_per_clus = 8'd8;
        cfg_ent_per_sec = 8'd16;
        cfg_fat_start = '0;
        cfg_fat_words = 11'd128;
        cur_cluster = '0;
        entry_pos = '0;
        sector_pos = '0;
        fat_pending = 1'b0;
        walk_ended = 1'b1;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_after_reset();
        test_chain_ends();
        test_counter_limits();
        test_random_walks(365, 0, 0, 1'b1);
        test_random_walks(365, 76, 0, 1'b0);
        test_random_walks(365, 0, 76, 1'b0);
        test_random_walks(365, 34, 34, 1'b0);

        if (awaited_beats.size() != 0) begin
            count_failure($sformatf("%0d beats never arrived", awaited_beats.size()));
        end
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/fdw_pkg.sv
sv/fat32_directory_walker.sv
tb/tb_top.sv
